FILE: rtl/core/hcc_pkg.sv
// hcc_pkg: widths, limits and the per-level datapath record for the hilbert curve converter
// no dependencies; used by hcc_step and hilbert_curve_converter

package hcc_pkg;

    // field widths
    localparam int COORD_W = 16;
    localparam int POS_W   = 32;
    localparam int ORD_W   = 5;

    // largest supported curve order
    localparam logic [ORD_W-1:0] ORD_MAX = 5'd16;

    // request opcodes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // working registers of one conversion
    typedef struct packed {
        logic [POS_W-1:0]   acc;   // position being built (encode) or consumed (decode)
        logic [COORD_W-1:0] x;     // column, current level aligned to the top bit
        logic [COORD_W-1:0] y;     // row, current level aligned to the top bit
        logic [COORD_W-1:0] mask;  // decode: coordinate bits filled so far
    } lvl_state_t;

endpackage

FILE: rtl/core/hcc_step.sv
// hcc_step: one bit level of hilbert encode or decode, shared by both directions
// depends on hcc_pkg

module hcc_step
(
    input  logic               opcode,
    input  hcc_pkg::lvl_state_t cur,
    output hcc_pkg::lvl_state_t nxt
);

    logic                        rx;
    logic                        ry;
    logic [hcc_pkg::COORD_W-2:0] lx;
    logic [hcc_pkg::COORD_W-2:0] ly;
    logic [hcc_pkg::COORD_W-1:0] cx;
    logic [hcc_pkg::COORD_W-1:0] cy;

    always_comb
    begin
        nxt = cur;
        lx  = '0;
        ly  = '0;
        cx  = '0;
        cy  = '0;
        if (opcode == hcc_pkg::OP_ENCODE)
        begin
            // top level bits give the quadrant, code is (3*rx) xor ry
            rx = cur.x[hcc_pkg::COORD_W-1];
            ry = cur.y[hcc_pkg::COORD_W-1];
            lx = cur.x[hcc_pkg::COORD_W-2:0];
            ly = cur.y[hcc_pkg::COORD_W-2:0];
            // rotate the lower bits
            if (!ry)
            begin
                if (rx)
                begin
                    lx = ~lx;
                    ly = ~ly;
                end
                nxt.x = {ly, 1'b0};
                nxt.y = {lx, 1'b0};
            end
            else
            begin
                nxt.x = {lx, 1'b0};
                nxt.y = {ly, 1'b0};
            end
            nxt.acc = {cur.acc[hcc_pkg::POS_W-3:0], rx, rx ^ ry};
        end
        else
        begin
            // low two position bits give the quadrant
            rx = cur.acc[1];
            ry = cur.acc[0] ^ cur.acc[1];
            cx = cur.x;
            cy = cur.y;
            // rotate the partial coordinates built so far
            if (!ry)
            begin
                if (rx)
                begin
                    cx = cx ^ cur.mask;
                    cy = cy ^ cur.mask;
                end
                nxt.x = {rx, cy[hcc_pkg::COORD_W-1:1]};
                nxt.y = {ry, cx[hcc_pkg::COORD_W-1:1]};
            end
            else
            begin
                nxt.x = {rx, cx[hcc_pkg::COORD_W-1:1]};
                nxt.y = {ry, cy[hcc_pkg::COORD_W-1:1]};
            end
            nxt.mask = {1'b1, cur.mask[hcc_pkg::COORD_W-1:1]};
            nxt.acc  = {2'b00, cur.acc[hcc_pkg::POS_W-1:2]};
        end
    end

endmodule

FILE: rtl/core/hilbert_curve_converter.sv
// hilbert_curve_converter: top level, sequencer around the shared level unit
// depends on hcc_pkg and hcc_step
// a start transfer runs one level in hcc_step per curve order level (order saturated at 16)
// a new request is taken only while idle; the levels run one bit level per cycle in hcc_step
// busy is high from the start transfer until done rises
// done shows for one cycle; the result holds until the next result; the receiver cannot stall it
// reset (rst_n, async low) returns the sequencer to idle and clears done

module hilbert_curve_converter
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         opcode,
    input  logic [hcc_pkg::ORD_W-1:0]    curve_order,
    input  logic [hcc_pkg::COORD_W-1:0]  column,
    input  logic [hcc_pkg::COORD_W-1:0]  row,
    input  logic [hcc_pkg::POS_W-1:0]    position_in,
    output logic                         done,
    output logic [hcc_pkg::POS_W-1:0]    position_out,
    output logic [hcc_pkg::COORD_W-1:0]  column_out,
    output logic [hcc_pkg::COORD_W-1:0]  row_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                        state_reg, state_next;
    logic [hcc_pkg::ORD_W-1:0]   cnt_reg, cnt_next;
    logic [hcc_pkg::ORD_W-1:0]   shift_reg, shift_next;
    logic                        op_reg, op_next;
    hcc_pkg::lvl_state_t         work_reg, work_next;
    logic                        done_reg, done_next;
    logic [hcc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [hcc_pkg::COORD_W-1:0] col_reg, col_next;
    logic [hcc_pkg::COORD_W-1:0] row_reg, row_next;

    logic [hcc_pkg::ORD_W-1:0]   ord_sat;
    logic [hcc_pkg::ORD_W-1:0]   ord_shift;
    hcc_pkg::lvl_state_t         step_out;

    // shared level unit
    hcc_step u_step
    (
        .opcode (op_reg),
        .cur    (work_reg),
        .nxt    (step_out)
    );

    // saturate the order and find the alignment shift
    assign ord_sat   = (curve_order > hcc_pkg::ORD_MAX) ? hcc_pkg::ORD_MAX : curve_order;
    assign ord_shift = hcc_pkg::ORD_MAX - ord_sat;

    // sequencer and datapath next values
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        op_next    = op_reg;
        work_next  = work_reg;
        done_next  = 1'b0;
        pos_next   = pos_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next     = ST_RUN;
                    cnt_next       = ord_sat;
                    shift_next     = ord_shift;
                    op_next        = opcode;
                    // encode builds the position from zero, decode consumes the input
                    work_next.acc  = (opcode == hcc_pkg::OP_ENCODE) ? '0 : position_in;
                    work_next.x    = column << ord_shift;
                    work_next.y    = row << ord_shift;
                    work_next.mask = '0;
                end
            end
            ST_RUN:
            begin
                if (cnt_reg != '0)
                begin
                    work_next = step_out;
                    cnt_next  = cnt_reg - 5'd1;
                end
                else
                begin
                    // all levels done: load the result transfer
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (op_reg == hcc_pkg::OP_ENCODE)
                    begin
                        pos_next = work_reg.acc;
                        col_next = '0;
                        row_next = '0;
                    end
                    else
                    begin
                        pos_next = '0;
                        col_next = work_reg.x >> shift_reg;
                        row_next = work_reg.y >> shift_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        op_reg    <= op_next;
        work_reg  <= work_next;
        pos_reg   <= pos_next;
        col_reg   <= col_next;
        row_reg   <= row_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign position_out = pos_reg;
    assign column_out   = col_reg;
    assign row_out      = row_reg;

endmodule

FILE: dv/tb_hilbert_curve_converter.sv
`timescale 1ns / 1ps
// tb_hilbert_curve_converter: self-checking testbench for the hilbert curve converter
// depends on hcc_pkg and hilbert_curve_converter; directed table then random traffic

module tb_hilbert_curve_converter;

    import hcc_pkg::*;

    localparam int unsigned QUAD_MUL         = 3;
    localparam int          NUM_DIRECTED     = 25;
    localparam int          RANDOM_PER_PHASE = 460;
    localparam int          DRAIN_CYCLES     = 20;
    localparam int          MAX_REPORTED     = 10;

    // one request as the sender presents it
    typedef struct packed {
        logic               opcode;
        logic [ORD_W-1:0]   curve_order;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [POS_W-1:0]   position_in;
    } request_t;

    // one conversion result
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } conversion_t;

    // directed row: request, plus a hand-written answer where typed is set
    typedef struct packed {
        request_t    req;
        logic        typed;
        conversion_t answer;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               opcode = OP_ENCODE;
    logic [ORD_W-1:0]   curve_order = '0;
    logic [COORD_W-1:0] column = '0;
    logic [COORD_W-1:0] row = '0;
    logic [POS_W-1:0]   position_in = '0;
    logic               done;
    logic [POS_W-1:0]   position_out;
    logic [COORD_W-1:0] column_out;
    logic [COORD_W-1:0] row_out;

    conversion_t expected_conversions[$];
    int unsigned error_count = 0;

    // extremes, every opcode, order zero, saturation and ignored high bits
    directed_row_t directed_rows [0:NUM_DIRECTED-1] = '{
        '{'{OP_ENCODE, 5'd0,  16'hFFFF, 16'hFFFF, 32'hFFFFFFFF}, 1'b1, '{32'h0, 16'h0, 16'h0}},
        '{'{OP_DECODE, 5'd0,  16'hFFFF, 16'hFFFF, 32'hFFFFFFFF}, 1'b1, '{32'h0, 16'h0, 16'h0}},
        '{'{OP_ENCODE, 5'd1,  16'h0000, 16'h0000, 32'h00000000}, 1'b1, '{32'h0, 16'h0, 16'h0}},
        '{'{OP_ENCODE, 5'd1,  16'h0000, 16'h0001, 32'h00000000}, 1'b1, '{32'h1, 16'h0, 16'h0}},
        '{'{OP_ENCODE, 5'd1,  16'h0001, 16'h0001, 32'h00000000}, 1'b1, '{32'h2, 16'h0, 16'h0}},
        '{'{OP_ENCODE, 5'd1,  16'h0001, 16'h0000, 32'h00000000}, 1'b1, '{32'h3, 16'h0, 16'h0}},
        '{'{OP_ENCODE, 5'd1,  16'hFFFE, 16'hFFFF, 32'hFFFFFFFF}, 1'b1, '{32'h1, 16'h0, 16'h0}},
        '{'{OP_DECODE, 5'd1,  16'h0000, 16'h0000, 32'h00000000}, 1'b1, '{32'h0, 16'h0, 16'h0}},
        '{'{OP_DECODE, 5'd1,  16'h0000, 16'h0000, 32'h00000001}, 1'b1, '{32'h0, 16'h0, 16'h1}},
        '{'{OP_DECODE, 5'd1,  16'h0000, 16'h0000, 32'h00000002}, 1'b1, '{32'h0, 16'h1, 16'h1}},
        '{'{OP_DECODE, 5'd1,  16'h0000, 16'h0000, 32'h00000003}, 1'b1, '{32'h0, 16'h1, 16'h0}},
        '{'{OP_DECODE, 5'd1,  16'hFFFF, 16'hFFFF, 32'hFFFFFFFE}, 1'b1, '{32'h0, 16'h1, 16'h1}},
        '{'{OP_ENCODE, 5'd16, 16'hFFFF, 16'h0000, 32'h00000000}, 1'b1,
          '{32'hFFFFFFFF, 16'h0, 16'h0}},
        '{'{OP_DECODE, 5'd16, 16'h0000, 16'h0000, 32'hFFFFFFFF}, 1'b1,
          '{32'h0, 16'hFFFF, 16'h0}},
        '{'{OP_ENCODE, 5'd16, 16'h0000, 16'h0000, 32'hFFFFFFFF}, 1'b1, '{32'h0, 16'h0, 16'h0}},
        '{'{OP_DECODE, 5'd16, 16'hFFFF, 16'hFFFF, 32'h00000000}, 1'b1, '{32'h0, 16'h0, 16'h0}},
        '{'{OP_ENCODE, 5'd31, 16'hFFFF, 16'h0000, 32'h00000000}, 1'b1,
          '{32'hFFFFFFFF, 16'h0, 16'h0}},
        '{'{OP_DECODE, 5'd31, 16'h0000, 16'h0000, 32'hFFFFFFFF}, 1'b1,
          '{32'h0, 16'hFFFF, 16'h0}},
        '{'{OP_ENCODE, 5'd16, 16'hFFFF, 16'hFFFF, 32'h00000000}, 1'b0, '0},
        '{'{OP_DECODE, 5'd17, 16'h0000, 16'h0000, 32'hAAAA5555}, 1'b0, '0},
        '{'{OP_ENCODE, 5'd8,  16'h1234, 16'hABCD, 32'h00000000}, 1'b0, '0},
        '{'{OP_DECODE, 5'd8,  16'h0000, 16'h0000, 32'hDEADBEEF}, 1'b0, '0},
        '{'{OP_ENCODE, 5'd15, 16'h7FFF, 16'h8000, 32'h00000000}, 1'b0, '0},
        '{'{OP_DECODE, 5'd2,  16'h0000, 16'h0000, 32'h0000000B}, 1'b0, '0},
        '{'{OP_DECODE, 5'd16, 16'h0000, 16'h0000, 32'h80000001}, 1'b0, '0}
    };

    hilbert_curve_converter DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .curve_order  (curve_order),
        .column       (column),
        .row          (row),
        .position_in  (position_in),
        .done         (done),
        .position_out (position_out),
        .column_out   (column_out),
        .row_out      (row_out)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("hilbert_curve_converter test failed");
        $finish;
    end

    // expected result of one request: xy to curve position or back
    function automatic conversion_t hilbert_convert(input request_t req);
        conversion_t      res;
        logic [ORD_W-1:0] ord;
        logic [31:0]      xs;
        logic [31:0]      ys;
        logic [31:0]      swap_tmp;
        logic [31:0]      lvl_bit;
        logic [31:0]      below;
        logic [31:0]      curve_pos;
        logic             rx;
        logic             ry;
        res = '0;
        ord = (req.curve_order > ORD_MAX) ? ORD_MAX : req.curve_order;
        if (req.opcode == OP_ENCODE)
        begin
            // top level down, quadrant code then rotate the lower bits
            below     = (32'd1 << ord) - 32'd1;
            xs        = {16'd0, req.column} & below;
            ys        = {16'd0, req.row} & below;
            curve_pos = '0;
            for (int s = ord; s > 0; s--)
            begin
                lvl_bit   = 32'd1 << (s - 1);
                below     = lvl_bit - 32'd1;
                rx        = |(xs & lvl_bit);
                ry        = |(ys & lvl_bit);
                curve_pos = curve_pos + (((32'(rx) * QUAD_MUL) ^ 32'(ry)) << (2 * (s - 1)));
                if (!ry && rx)
                begin
                    xs = ~xs & below;
                    ys = ~ys & below;
                end
                else
                begin
                    xs = xs & below;
                    ys = ys & below;
                end
                if (!ry)
                begin
                    swap_tmp = xs;
                    xs       = ys;
                    ys       = swap_tmp;
                end
            end
            res.position = curve_pos;
        end
        else
        begin
            // bottom level up, rotate partial coordinates then add the level bits
            curve_pos = req.position_in;
            if (ord < ORD_MAX)
                curve_pos = curve_pos & ((32'd1 << (2 * ord)) - 32'd1);
            xs = '0;
            ys = '0;
            for (int s = 1; s <= ord; s++)
            begin
                lvl_bit = 32'd1 << (s - 1);
                rx      = curve_pos[1];
                ry      = curve_pos[0] ^ rx;
                if (!ry)
                begin
                    if (rx)
                    begin
                        xs = (lvl_bit - 32'd1) - xs;
                        ys = (lvl_bit - 32'd1) - ys;
                    end
                    swap_tmp = xs;
                    xs       = ys;
                    ys       = swap_tmp;
                end
                if (rx)
                    xs = xs | lvl_bit;
                if (ry)
                    ys = ys | lvl_bit;
                curve_pos = curve_pos >> 2;
            end
            res.column = xs[COORD_W-1:0];
            res.row    = ys[COORD_W-1:0];
        end
        return res;
    endfunction

    // random request, mostly legal orders, some above the limit
    function automatic request_t random_request();
        request_t req;
        req.opcode      = 1'($urandom_range(1));
        req.curve_order = ($urandom_range(99) < 10) ? ORD_W'($urandom_range(31, 17))
                                                    : ORD_W'($urandom_range(16));
        req.column      = COORD_W'($urandom);
        req.row         = COORD_W'($urandom);
        req.position_in = POS_W'($urandom);
        return req;
    endfunction

    // present one request, wait for the transfer and record what it should give
    task automatic issue_conversion(input request_t req, input logic typed,
                                    input conversion_t answer);
        opcode      <= req.opcode;
        curve_order <= req.curve_order;
        column      <= req.column;
        row         <= req.row;
        position_in <= req.position_in;
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_conversions.push_back(typed ? answer : hilbert_convert(req));
    endtask

    // sender idle cycles after a transfer
    task automatic sender_gap(input int unsigned idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (expected_conversions.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int unsigned   idle_pct;
        directed_row_t drow;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            drow = directed_rows[i];
            issue_conversion(drow.req, drow.typed, drow.answer);
            sender_gap(22);
        end
        drain_results();

        // random traffic: light idling, heavy idling, back to back
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 22 : (phase == 1) ? 63 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                issue_conversion(random_request(), 1'b0, '0);
                sender_gap(idle_pct);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_conversions.size() == 0)
            $display("hilbert_curve_converter test passed");
        else
            $display("hilbert_curve_converter test failed");
        $finish;
    end

    // result checker
    always @(posedge clk)
    begin
        conversion_t want;
        if (rst_n && done)
        begin
            if (expected_conversions.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTED)
                    $display("unexpected result: pos %h col %h row %h",
                             position_out, column_out, row_out);
            end
            else
            begin
                want = expected_conversions.pop_front();
                if (position_out !== want.position || column_out !== want.column ||
                    row_out !== want.row)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTED)
                        $display("mismatch: exp pos %h col %h row %h, got pos %h col %h row %h",
                                 want.position, want.column, want.row,
                                 position_out, column_out, row_out);
                end
            end
        end
    end

endmodule
